// ===== rtl/core/arh_pkg.sv =====
// Shared types and codes for the auto-ranging histogram.
`default_nettype none
package arh_pkg;
   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_MODE = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_RANGE_LOW  = 2'd0,
      CSR_WIDTH_LOG2 = 2'd1,
      CSR_AUTO_RANGE = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MERGE_RD0,
      ST_MERGE_RD1,
      ST_MERGE_WR,
      ST_ZERO,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_READ_RD,
      ST_MODE_RD,
      ST_MODE_END,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/arh_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module arh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/auto_ranging_uniform_histogram_top.sv =====
// Auto-ranging uniform histogram: sequencer around one bin-count memory.
// Each widening step merges bin pairs (two reads and a write per destination bin), then clears the freed half.
// Throughput: one item in flight; the next is taken the cycle after the result is accepted.
// Reset (synchronous, active high) clears the control registers and runs a clearing pass
// over the memory; a range_low or width_log2 write starts the same pass.
`default_nettype none
module auto_ranging_uniform_histogram_top
   import arh_pkg::*;
#(
   parameter int N_BINS         = 64,
   parameter int COUNT_BITS     = 32,
   parameter int MAX_WIDTH_LOG2 = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic signed [31:0] req_sample,
   input  wire logic [5:0]  req_bin_select,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_bin_index,
   output logic [31:0]      rsp_bin_count,
   output logic signed [39:0] rsp_current_low,
   output logic [5:0]       rsp_current_width_log2,
   output logic [31:0]      rsp_rescale_total,
   output logic             rsp_clamped
);
   localparam int AW = $clog2(N_BINS);
   localparam int HALF = N_BINS / 2;
   localparam int EW = $clog2(MAX_WIDTH_LOG2 + 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [AW-1:0] LAST = AW'(N_BINS - 1);
   // low edge kept wide enough for any widening at MAX_WIDTH_LOG2
   localparam int LW = 34 + AW + MAX_WIDTH_LOG2;

   state_type state_ff, state_in;

   logic signed [31:0] reg_low_ff;
   logic [4:0]  reg_wlog_ff;
   logic        reg_auto_ff;
   logic signed [LW-1:0] low_ff, low_in;
   logic [EW-1:0] wexp_ff, wexp_in;
   logic [31:0] resc_ff, resc_in;
   logic        stepped_ff, stepped_in;
   logic        merge_up_ff, merge_up_in;
   logic [AW-1:0] ptr_ff, ptr_in;     // destination / scan index
   logic [AW:0]   cnt_ff, cnt_in;     // steps done in the current pass
   logic [COUNT_BITS-1:0] tmp_ff, tmp_in, best_ff, best_in;
   func_type func_ff, func_in;
   logic signed [31:0] samp_ff, samp_in;
   logic [5:0]  sel_ff, sel_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic        clamp_ff, clamp_in;
   logic        out_v_ff, out_v_in;
   logic [5:0]  o_idx_ff, o_idx_in;
   logic [31:0] o_cnt_ff, o_cnt_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [COUNT_BITS-1:0] ram_wd, ram_rd;

   arh_ram #(.WIDTH(COUNT_BITS), .DEPTH(N_BINS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   // range tests against current low edge and span
   logic signed [LW-1:0] s_ext, span, high, diff;
   logic below, above, can_widen;
   logic [COUNT_BITS:0] psum;
   logic [COUNT_BITS-1:0] sat_sum, inc;
   logic [LW-1:0] shifted;
   logic reinit;

   always_comb begin
      s_ext = LW'(samp_ff);
      span = LW'(N_BINS) <<< wexp_ff;
      high = low_ff + span;
      diff = s_ext - low_ff;
      below = s_ext < low_ff;
      above = s_ext >= high;
      can_widen = wexp_ff < EW'(MAX_WIDTH_LOG2);
      psum = {1'b0, tmp_ff} + {1'b0, ram_rd};
      sat_sum = psum[COUNT_BITS] ? CNT_MAX : psum[COUNT_BITS-1:0];
      inc = (ram_rd == CNT_MAX) ? CNT_MAX : ram_rd + 1'b1;
      shifted = diff >> wexp_ff;
      reinit = csr_write && (csr_index == CSR_RANGE_LOW || csr_index == CSR_WIDTH_LOG2);
   end

   assign req_stall = (state_ff != ST_IDLE) || out_v_ff || reinit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (cnt_ff == (AW+1)'(N_BINS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (func_type'(req_func))
                  FUNC_ADD:  state_in = ST_CHECK;
                  FUNC_READ: state_in = ST_READ_RD;
                  FUNC_MODE: state_in = ST_MODE_RD;
                  default:   state_in = ST_OUT;
               endcase
            end
         end
         ST_CHECK: begin
            if (reg_auto_ff && can_widen && (below || above)) state_in = ST_MERGE_RD0;
            else state_in = ST_ADD_RD;
         end
         ST_MERGE_RD0: state_in = ST_MERGE_RD1;
         ST_MERGE_RD1: state_in = ST_MERGE_WR;
         ST_MERGE_WR:  state_in = (cnt_ff == (AW+1)'(HALF - 1)) ? ST_ZERO : ST_MERGE_RD0;
         ST_ZERO:      if (cnt_ff == (AW+1)'(HALF - 1)) state_in = ST_CHECK;
         ST_ADD_RD:    state_in = ST_ADD_WR;
         ST_ADD_WR:    state_in = ST_OUT;
         ST_READ_RD:   state_in = ST_OUT;
         ST_MODE_RD:   if (cnt_ff == (AW+1)'(N_BINS - 1)) state_in = ST_MODE_END;
         ST_MODE_END:  state_in = ST_OUT;
         ST_OUT:       state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
      if (reinit) state_in = ST_CLEAR;
   end

   // datapath and memory control
   always_comb begin
      low_in = low_ff; wexp_in = wexp_ff; resc_in = resc_ff;
      stepped_in = stepped_ff; merge_up_in = merge_up_ff;
      ptr_in = ptr_ff; cnt_in = cnt_ff; tmp_in = tmp_ff; best_in = best_ff;
      func_in = func_ff; samp_in = samp_ff; sel_in = sel_ff;
      idx_in = idx_ff; clamp_in = clamp_ff;
      out_v_in = out_v_ff; o_idx_in = o_idx_ff; o_cnt_in = o_cnt_ff;
      ram_we = 1'b0; ram_addr = ptr_ff; ram_wd = '0;
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1; ram_addr = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            cnt_in = '0; stepped_in = 1'b0;
            if (req_valid && !req_stall) begin
               func_in = func_type'(req_func);
               samp_in = req_sample; sel_in = req_bin_select;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (reg_auto_ff && can_widen && below) begin
               merge_up_in = 1'b1; ptr_in = LAST;
               low_in = low_ff - span;
            end else if (reg_auto_ff && can_widen && above) begin
               merge_up_in = 1'b0; ptr_in = '0;
            end else begin
               if (stepped_ff && resc_ff != '1) resc_in = resc_ff + 1'b1;
               clamp_in = below || above;
               if (below) idx_in = '0;
               else if (above || shifted >= LW'(N_BINS)) idx_in = LAST;
               else idx_in = shifted[AW-1:0];
            end
         end
         ST_MERGE_RD0: begin
            // source pair for destination d: up -> 2d-N, 2d-N+1; low -> 2d, 2d+1
            ram_addr = merge_up_ff ? AW'({ptr_ff, 1'b0}) : AW'({ptr_ff, 1'b0});
         end
         ST_MERGE_RD1: begin
            tmp_in = ram_rd;
            ram_addr = AW'({ptr_ff, 1'b1});
         end
         ST_MERGE_WR: begin
            ram_we = 1'b1; ram_addr = ptr_ff; ram_wd = sat_sum;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(HALF - 1)) begin
               cnt_in = '0;
               ptr_in = merge_up_ff ? '0 : AW'(HALF);
            end else begin
               ptr_in = merge_up_ff ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
            end
         end
         ST_ZERO: begin
            ram_we = 1'b1; ram_addr = ptr_ff;
            ptr_in = ptr_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(HALF - 1)) begin
               wexp_in = wexp_ff + 1'b1; stepped_in = 1'b1; cnt_in = '0;
            end
         end
         ST_ADD_RD: ram_addr = idx_ff;
         ST_ADD_WR: begin
            ram_we = 1'b1; ram_addr = idx_ff; ram_wd = inc;
            o_idx_in = 6'(idx_ff); o_cnt_in = 32'(inc);
         end
         ST_READ_RD: begin
            ram_addr = sel_ff[AW-1:0];
            o_idx_in = sel_ff; clamp_in = 1'b0;
         end
         ST_MODE_RD: begin
            ram_addr = cnt_ff[AW-1:0]; clamp_in = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            // compare the word read last cycle (index cnt-1)
            if (cnt_ff == '0) begin
               best_in = '0; o_idx_in = '0;
            end else if (best_ff <= ram_rd || cnt_ff == (AW+1)'(1)) begin
               best_in = ram_rd; o_idx_in = 6'(cnt_ff - 1'b1);
            end
         end
         ST_MODE_END: begin
            if (best_ff <= ram_rd) begin
               best_in = ram_rd; o_idx_in = 6'(LAST);
            end
         end
         ST_OUT: begin
            out_v_in = 1'b1;
            case (func_ff)
               FUNC_READ: o_cnt_in = ({26'd0, sel_ff} < 32'(N_BINS)) ? 32'(ram_rd) : '0;
               FUNC_MODE: o_cnt_in = 32'(best_ff);
               FUNC_ADD:  o_cnt_in = o_cnt_ff;
               default: begin
                  o_idx_in = '0; o_cnt_in = '0; clamp_in = 1'b0;
               end
            endcase
         end
         default: ;
      endcase
      if (reinit) begin
         cnt_in = '0; resc_in = '0;
         low_in = (csr_index == CSR_RANGE_LOW) ? LW'(signed'(csr_data)) : LW'(reg_low_ff);
         wexp_in = EW'((csr_index == CSR_WIDTH_LOG2) ? csr_data[4:0] : reg_wlog_ff);
      end
   end

   // merge source address fix-up for the upward merge (sources 2d-N, 2d-N+1)
   // is covered by AW-bit wrap: {d,0} mod N == 2d-N for d >= N/2.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         reg_low_ff <= '0; reg_wlog_ff <= '0; reg_auto_ff <= 1'b0;
         low_ff <= '0; wexp_ff <= '0; resc_ff <= '0;
         stepped_ff <= 1'b0; cnt_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write && csr_index == CSR_RANGE_LOW) reg_low_ff <= csr_data;
         if (csr_write && csr_index == CSR_WIDTH_LOG2) reg_wlog_ff <= csr_data[4:0];
         if (csr_write && csr_index == CSR_AUTO_RANGE) reg_auto_ff <= csr_data[0];
         low_ff <= low_in; wexp_ff <= wexp_in; resc_ff <= resc_in;
         stepped_ff <= stepped_in; cnt_ff <= cnt_in; out_v_ff <= out_v_in;
      end
      merge_up_ff <= merge_up_in; ptr_ff <= ptr_in; tmp_ff <= tmp_in;
      best_ff <= best_in; func_ff <= func_in; samp_ff <= samp_in;
      sel_ff <= sel_in; idx_ff <= idx_in; clamp_ff <= clamp_in;
      o_idx_ff <= o_idx_in; o_cnt_ff <= o_cnt_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_bin_index = o_idx_ff;
   assign rsp_bin_count = o_cnt_ff;
   assign rsp_current_low = low_ff[39:0];
   assign rsp_current_width_log2 = 6'(wexp_ff);
   assign rsp_rescale_total = resc_ff;
   assign rsp_clamped = clamp_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while result pending");
   a_wexp_cap: assert property (@(posedge clock) disable iff (reset)
      wexp_ff <= EW'(MAX_WIDTH_LOG2)) else $error("width exponent beyond limit");
   a_resc_mono: assert property (@(posedge clock) disable iff (reset)
      !reinit |=> resc_ff >= $past(resc_ff))
      else $error("rescale count went down");
endmodule
`default_nettype wire
